// File: hw/rtl/wds_pkg.sv
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types and constants of the weighted descriptor splitter: word
// layouts of both channels, the task word between front and back, the
// configuration register indexes and the table sizes.
// ----------------------------------------------------------------------------
package wds_pkg;

	// queue pair offset table
	localparam int QUEUE_PAIRS = 1024;
	localparam int QP_IDX_W    = (QUEUE_PAIRS > 1) ? $clog2(QUEUE_PAIRS) : 1;

	// scheduling groups with a granularity register
	localparam int GROUPS         = 4;
	localparam int NUM_GRAN_REGS  = 4;
	localparam logic [15:0] GRAN_RESET = 16'd1024;

	// task queue between front and back, depth a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP0_GRAN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP1_GRAN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP2_GRAN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP3_GRAN = 8'd3;

	// weight times granularity
	localparam int QUANTUM_W = 24;

	// descriptor word
	typedef struct packed {
		logic [9:0]  queue_pair;
		logic        latency_class;
		logic        batch_start;
		logic [7:0]  qp_weight;
		logic [1:0]  sched_group;
		logic [31:0] desc_length;
		logic [63:0] local_address;
		logic [63:0] remote_address;
		logic [7:0]  desc_opcode;
		logic        signaled;
	} desc_word_t;

	// sub-descriptor word
	typedef struct packed {
		logic [9:0]  out_queue_pair;
		logic        out_high_priority;
		logic [31:0] sub_length;
		logic [63:0] sub_local_address;
		logic [63:0] sub_remote_address;
		logic [7:0]  out_opcode;
		logic        desc_complete;
		logic        completion_signal;
	} piece_word_t;

	// classified descriptor with its quantum, front to back
	typedef struct packed {
		logic [9:0]           queue_pair;
		logic                 latency_class;
		logic                 batch_start;
		logic [QUANTUM_W-1:0] quantum;
		logic [31:0]          desc_length;
		logic [63:0]          local_address;
		logic [63:0]          remote_address;
		logic [7:0]           desc_opcode;
		logic                 signaled;
	} task_t;

	// task queue status
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// File: hw/rtl/wds_front.sv
// ----------------------------------------------------------------------------
// wds_front
// Front part: holds the granularity registers, takes descriptor words,
// works out the batch quantum in one registered multiply and pushes the
// classified task into the queue.
// ----------------------------------------------------------------------------
module wds_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           desc_valid,
	output logic                           desc_stall,
	input  wds_pkg::desc_word_t            desc_word,
	input  logic                           hold,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wds_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           push,
	output wds_pkg::task_t                 push_task,
	input  wds_pkg::qstat_t                qstat
);

	logic [15:0]    gran_q [wds_pkg::NUM_GRAN_REGS];
	logic           valid_s1;
	wds_pkg::task_t task_s1;
	logic           stage_ready;
	logic           accept;
	logic [15:0]    gran;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < wds_pkg::NUM_GRAN_REGS; g++) begin
				gran_q[g] <= wds_pkg::GRAN_RESET;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				wds_pkg::CFG_GROUP0_GRAN: gran_q[0] <= cfg_data;
				wds_pkg::CFG_GROUP1_GRAN: gran_q[1] <= cfg_data;
				wds_pkg::CFG_GROUP2_GRAN: gran_q[2] <= cfg_data;
				wds_pkg::CFG_GROUP3_GRAN: gran_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// accept handshake
	assign stage_ready = !valid_s1 || !qstat.full;
	assign desc_stall  = hold || !stage_ready;
	assign accept      = desc_valid && !desc_stall;
	assign push        = valid_s1 && !qstat.full;
	assign push_task   = task_s1;

	// group granularity, zero outside the configured groups
	always_comb begin
		if (32'(desc_word.sched_group) < 32'(wds_pkg::GROUPS)) begin
			gran = gran_q[desc_word.sched_group];
		end else begin
			gran = '0;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload with the quantum product
	always_ff @(posedge clk) begin
		if (accept) begin
			task_s1.queue_pair     <= desc_word.queue_pair;
			task_s1.latency_class  <= desc_word.latency_class;
			task_s1.batch_start    <= desc_word.batch_start;
			task_s1.quantum        <= wds_pkg::QUANTUM_W'(desc_word.qp_weight) *
				wds_pkg::QUANTUM_W'(gran);
			task_s1.desc_length    <= desc_word.desc_length;
			task_s1.local_address  <= desc_word.local_address;
			task_s1.remote_address <= desc_word.remote_address;
			task_s1.desc_opcode    <= desc_word.desc_opcode;
			task_s1.signaled       <= desc_word.signaled;
		end
	end

endmodule

// File: hw/rtl/wds_queue.sv
// ----------------------------------------------------------------------------
// wds_queue
// Short first-in first-out queue of task words between front and back.
// ----------------------------------------------------------------------------
module wds_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wds_pkg::task_t  push_task,
	input  logic            pop,
	output wds_pkg::task_t  pop_task,
	output wds_pkg::qstat_t qstat
);

	wds_pkg::task_t                 entry_q [wds_pkg::QUEUE_DEPTH];
	logic [wds_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [wds_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [wds_pkg::QUEUE_PTR_W:0]   count_q;

	assign pop_task    = entry_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == (wds_pkg::QUEUE_PTR_W + 1)'(wds_pkg::QUEUE_DEPTH));

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_task;
		end
	end

endmodule

// File: hw/rtl/wds_back.sv
// ----------------------------------------------------------------------------
// wds_back
// Back part: clears the offset table after reset, reads the queue pair's
// offset, cuts the piece against the batch quantum, writes the offset back
// with forwarding, then adds the offset to both addresses.
// ----------------------------------------------------------------------------
module wds_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wds_pkg::task_t        pop_task,
	input  wds_pkg::qstat_t       qstat,
	output logic                  pop,
	output logic                  clr_busy,
	output logic                  piece_valid,
	input  logic                  piece_stall,
	output wds_pkg::piece_word_t  piece_word
);

	typedef struct packed {
		logic [9:0]  queue_pair;
		logic        high_priority;
		logic [31:0] sub_length;
		logic [31:0] offset;
		logic [63:0] local_address;
		logic [63:0] remote_address;
		logic [7:0]  opcode;
		logic        complete;
		logic        completion;
	} cut_t;

	logic [31:0]                      offset_q [wds_pkg::QUEUE_PAIRS];
	logic                             clr_busy_q;
	logic [wds_pkg::QP_IDX_W-1:0]     clr_idx_q;
	logic                             fwd_valid_q;
	logic [wds_pkg::QP_IDX_W-1:0]     fwd_idx_q;
	logic [31:0]                      fwd_data_q;
	logic [wds_pkg::QUANTUM_W-1:0]    qused_q;

	logic                             valid_s1;
	wds_pkg::task_t                   task_s1;
	logic [31:0]                      rd_data_s1;
	logic                             valid_s2;
	cut_t                             cut_s2;
	logic                             valid_s3;
	wds_pkg::piece_word_t             word_s3;

	logic                             s2_ready;
	logic                             s3_ready;
	logic                             adv_s1;
	logic [wds_pkg::QP_IDX_W-1:0]     rd_idx;
	logic [wds_pkg::QP_IDX_W-1:0]     idx_s1;
	logic                             qp_ok;
	logic [wds_pkg::QUANTUM_W-1:0]    qused_eff;
	logic [wds_pkg::QUANTUM_W-1:0]    left;
	logic                             have;
	logic [31:0]                      off_raw;
	logic [31:0]                      off;
	logic [31:0]                      remaining;
	logic [31:0]                      piece;
	logic                             done;
	logic                             emit;
	logic                             wr_item;
	logic [31:0]                      new_off;
	logic                             mem_we;
	logic [wds_pkg::QP_IDX_W-1:0]     mem_waddr;
	logic [31:0]                      mem_wdata;
	cut_t                             cut;

	// stage handshakes
	assign s3_ready = !valid_s3 || !piece_stall;
	assign s2_ready = !valid_s2 || s3_ready;
	assign adv_s1   = valid_s1 && s2_ready;
	assign pop      = !qstat.empty && !clr_busy_q && (!valid_s1 || adv_s1);
	assign clr_busy = clr_busy_q;
	assign rd_idx   = wds_pkg::QP_IDX_W'(pop_task.queue_pair);
	assign idx_s1   = wds_pkg::QP_IDX_W'(task_s1.queue_pair);

	// clearing pass over the offset table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == wds_pkg::QP_IDX_W'(wds_pkg::QUEUE_PAIRS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// offset table, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			offset_q[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rd_data_s1 <= offset_q[rd_idx];
		end
	end

	// cut the piece against the quantum
	always_comb begin
		qp_ok     = 32'(task_s1.queue_pair) < 32'(wds_pkg::QUEUE_PAIRS);
		qused_eff = task_s1.batch_start ? '0 : qused_q;
		have      = qused_eff < task_s1.quantum;
		left      = task_s1.quantum - qused_eff;
		off_raw   = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_data_s1;
		off       = (!qp_ok || (off_raw >= task_s1.desc_length)) ? '0 : off_raw;
		remaining = task_s1.desc_length - off;
		piece     = (remaining > 32'(left)) ? 32'(left) : remaining;
		done      = (piece == remaining);
		emit      = task_s1.latency_class || have;
		wr_item   = adv_s1 && !task_s1.latency_class && have && qp_ok;
		new_off   = done ? '0 : off + piece;

		cut.queue_pair     = task_s1.queue_pair;
		cut.high_priority  = task_s1.latency_class;
		cut.local_address  = task_s1.local_address;
		cut.remote_address = task_s1.remote_address;
		cut.opcode         = task_s1.desc_opcode;
		if (task_s1.latency_class) begin
			cut.sub_length = task_s1.desc_length;
			cut.offset     = '0;
			cut.complete   = 1'b1;
			cut.completion = task_s1.signaled;
		end else begin
			cut.sub_length = piece;
			cut.offset     = off;
			cut.complete   = done;
			cut.completion = done && task_s1.signaled;
		end
	end

	// table write port shared with the clearing pass
	assign mem_we    = clr_busy_q || wr_item;
	assign mem_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign mem_wdata = clr_busy_q ? '0 : new_off;

	// last written offset and batch quantum use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			fwd_idx_q   <= '0;
			fwd_data_q  <= '0;
			qused_q     <= '0;
		end else begin
			if (wr_item) begin
				fwd_valid_q <= 1'b1;
				fwd_idx_q   <= idx_s1;
				fwd_data_q  <= new_off;
			end
			if (adv_s1) begin
				if (!task_s1.latency_class && have) begin
					qused_q <= qused_eff + wds_pkg::QUANTUM_W'(piece);
				end else begin
					qused_q <= qused_eff;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (s2_ready) begin
				valid_s2 <= adv_s1 && emit;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (pop) begin
			task_s1 <= pop_task;
		end
		if (s2_ready && adv_s1) begin
			cut_s2 <= cut;
		end
		if (s3_ready && valid_s2) begin
			word_s3.out_queue_pair     <= cut_s2.queue_pair;
			word_s3.out_high_priority  <= cut_s2.high_priority;
			word_s3.sub_length         <= cut_s2.sub_length;
			word_s3.sub_local_address  <= cut_s2.local_address + 64'(cut_s2.offset);
			word_s3.sub_remote_address <= cut_s2.remote_address + 64'(cut_s2.offset);
			word_s3.out_opcode         <= cut_s2.opcode;
			word_s3.desc_complete      <= cut_s2.complete;
			word_s3.completion_signal  <= cut_s2.completion;
		end
	end

	assign piece_valid = valid_s3;
	assign piece_word  = word_s3;

endmodule

// File: hw/rtl/weighted_descriptor_splitter.sv
// ----------------------------------------------------------------------------
// weighted_descriptor_splitter
// Cuts bandwidth-class send descriptors into sub-descriptors bounded by the
// batch quantum and passes latency-class descriptors through whole.
// ----------------------------------------------------------------------------
// path: a descriptor passes the front stage register, the task queue and back stages s1, s2, s3
// throughput: one descriptor per cycle while piece_stall is low, set by the offset table's single
//   read-modify-write per cycle with forwarding of the last write
// reset: granularity registers return to 1024, then a clearing pass zeroes
//   the offset table entry by entry with desc_stall held high
// configuration writes are taken in any cycle, also during the clearing pass
module weighted_descriptor_splitter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           desc_valid,
	output logic                           desc_stall,
	input  wds_pkg::desc_word_t            desc_word,
	output logic                           piece_valid,
	input  logic                           piece_stall,
	output wds_pkg::piece_word_t           piece_word,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wds_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic            q_push;
	wds_pkg::task_t  q_push_task;
	logic            q_pop;
	wds_pkg::task_t  q_pop_task;
	wds_pkg::qstat_t q_stat;
	logic            clr_busy;

	// front: config, accept, quantum
	wds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.desc_word  (desc_word),
		.hold       (clr_busy),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (q_push),
		.push_task  (q_push_task),
		.qstat      (q_stat)
	);

	// task queue
	wds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_task (q_push_task),
		.pop       (q_pop),
		.pop_task  (q_pop_task),
		.qstat     (q_stat)
	);

	// back: offset table, cut, address add
	wds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_task    (q_pop_task),
		.qstat       (q_stat),
		.pop         (q_pop),
		.clr_busy    (clr_busy),
		.piece_valid (piece_valid),
		.piece_stall (piece_stall),
		.piece_word  (piece_word)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("task queue overflow");

	// nothing reaches the queue while the table is being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> q_stat.empty)
		else $error("task queued during clearing pass");

	// latency-class words always finish their descriptor
	a_latency_whole: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece_word.out_high_priority |-> piece_word.desc_complete)
		else $error("latency word not complete");

	// completion only on the final piece
	a_completion_final: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece_word.completion_signal |-> piece_word.desc_complete)
		else $error("completion on a partial piece");

endmodule
